// ===== hw/rtl/camera_rotate_and_move_macros.svh =====
// Assertion macros for the camera rotate and move block.
`ifndef CAMERA_ROTATE_AND_MOVE_MACROS_SVH
`define CAMERA_ROTATE_AND_MOVE_MACROS_SVH

// Consequent must hold in the same cycle.
`define CRM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("camera rotate and move check failed");

// Consequent must hold in the next cycle.
`define CRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("camera rotate and move check failed");

`endif

// ===== hw/rtl/crm_pkg.sv =====
// Shared constants, codes and tables for the camera rotate and move block.
package crm_pkg;

  localparam int ROT_ITER_DEF  = 16;
  localparam int POS_WIDTH_DEF = 32;

  localparam int STEP_W  = 21;
  localparam int DIR_W   = 16;
  localparam int VEC_W   = 25;
  localparam int ANG_W   = 29;
  localparam int CNT_W   = 5;
  localparam int SUM_W   = 50;
  localparam int LEN_W   = 26;
  localparam int NUM_W   = 40;
  localparam int MB_W    = 31;
  localparam int PROD_W  = 56;
  localparam int DLT_W   = 24;
  localparam int QUO_W   = 16;

  localparam int SQRT_STEPS = 25;
  localparam int DIV_STEPS  = 16;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(32768);
  localparam logic signed [DIR_W-1:0] UNIT = DIR_W'(16384);

  localparam logic signed [ANG_W-1:0] ANG_PI      = ANG_W'(52707179);
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(26353589);
  localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = ANG_W'(105414357);
  localparam logic signed [MB_W-1:0]  INV_GAIN    = MB_W'(652032874);

  localparam logic [1:0] ACT_ROTATE  = 2'd0;
  localparam logic [1:0] ACT_FORWARD = 2'd1;
  localparam logic [1:0] ACT_BACK    = 2'd2;

  function automatic logic signed [ANG_W-1:0] atan_step(input logic [CNT_W-1:0] i);
    logic signed [ANG_W-1:0] r;
    case (i)
      5'd0: r = ANG_W'(13176795);
      5'd1: r = ANG_W'(7778716);
      5'd2: r = ANG_W'(4110060);
      5'd3: r = ANG_W'(2086331);
      5'd4: r = ANG_W'(1047214);
      5'd5: r = ANG_W'(524117);
      5'd6: r = ANG_W'(262123);
      5'd7: r = ANG_W'(131069);
      5'd8: r = ANG_W'(65536);
      default: r = (i <= 5'd24) ? (ANG_W'(1) << (5'd24 - i)) : '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/crm_cmd_if.sv =====
// Command channel: action and angles with valid/ready.
interface crm_cmd_if;
  import crm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic signed [DIR_W-1:0]  turn_angle;
  logic signed [DIR_W-1:0]  tilt_offset;

  modport source(output valid, action, turn_angle, tilt_offset, input ready);
  modport sink(input valid, action, turn_angle, tilt_offset, output ready);
endinterface

// ===== hw/rtl/crm_res_if.sv =====
// Result channel: full camera state and flags with valid/ready.
interface crm_res_if #(
  parameter int PW = crm_pkg::POS_WIDTH_DEF
);
  import crm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DIR_W-1:0] view_x;
  logic signed [DIR_W-1:0] view_y;
  logic signed [DIR_W-1:0] view_z;
  logic signed [PW-1:0]    where_x;
  logic signed [PW-1:0]    where_y;
  logic signed [PW-1:0]    where_z;
  logic                    degenerate;
  logic                    clipped;

  modport source(output valid, view_x, view_y, view_z, where_x, where_y, where_z,
                 degenerate, clipped, input ready);
  modport sink(input valid, view_x, view_y, view_z, where_x, where_y, where_z,
               degenerate, clipped, output ready);
endinterface

// ===== hw/rtl/camera_rotate_and_move.sv =====
// Camera direction and position unit with a shared multiplier, serial root and divider.
`include "camera_rotate_and_move_macros.svh"
// Holds a unit view direction (Q2.14) and a position (Q16.16, POSITION_WIDTH bits).
// A rotate beat runs ROTATE_ITERATIONS CORDIC steps, then gain correction and
// squaring on the one shared multiplier, a bit-serial square root and three
// restoring divides. A move beat updates each component in turn on the shared
// multiplier; an unused action only reports the current state. The command side is
// not ready while a beat is in work; a finished result waits in the output register
// and the next command is taken meanwhile. move_step may be written at any idle time.
module camera_rotate_and_move #(
  parameter int ROTATE_ITERATIONS = crm_pkg::ROT_ITER_DEF,
  parameter int POSITION_WIDTH    = crm_pkg::POS_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [crm_pkg::STEP_W-1:0]  wr_data,
  crm_cmd_if.sink                     cmd,
  crm_res_if.source                   res
);
  import crm_pkg::*;

  localparam int PW = POSITION_WIDTH;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WRAP   = 4'd1;
  localparam logic [3:0] S_FOLD   = 4'd2;
  localparam logic [3:0] S_CORDIC = 4'd3;
  localparam logic [3:0] S_GAIN   = 4'd4;
  localparam logic [3:0] S_SQ     = 4'd5;
  localparam logic [3:0] S_SQRT   = 4'd6;
  localparam logic [3:0] S_DPREP  = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_DSTORE = 4'd9;
  localparam logic [3:0] S_MOVE   = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0]              state;
  logic [STEP_W-1:0]       move_step;
  logic signed [DIR_W-1:0] dir_x, dir_y, dir_z;
  logic signed [PW-1:0]    pos_x, pos_y, pos_z;

  logic signed [VEC_W-1:0] vx, vy, vz;
  logic signed [ANG_W-1:0] ang;
  logic [CNT_W-1:0]        cnt;
  logic [1:0]              comp;
  logic                    ph;
  logic                    back;
  logic                    degen;
  logic                    clip;
  logic [SUM_W-1:0]        acc;
  logic [SUM_W-1:0]        root;
  logic [LEN_W-1:0]        len;
  logic [NUM_W-1:0]        rem;
  logic [QUO_W-1:0]        quot;
  logic                    neg;
  logic signed [PROD_W-1:0] prod;

  logic signed [VEC_W-1:0] mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [VEC_W-1:0] sel_v;
  logic signed [DIR_W-1:0] sel_dir;
  logic signed [PW-1:0]    sel_pos;
  logic signed [VEC_W-1:0] cor_sx, cor_sz;
  logic signed [ANG_W-1:0] cor_a;
  logic [SUM_W-1:0]        sq_bit, sq_test;
  logic [SUM_W-1:0]        root_next;
  logic                    sq_ge;
  logic [NUM_W+1:0]        dv_t;
  logic                    dv_ge;
  logic [VEC_W-1:0]        dp_mag;
  logic [NUM_W-1:0]        dp_num;
  logic [QUO_W-1:0]        q_clamp;
  logic signed [DIR_W-1:0] q_signed;
  logic signed [PROD_W-1:0] mv_sum;
  logic signed [DLT_W-1:0] mv_delta;
  logic signed [PW:0]      mv_r;
  logic signed [PW-1:0]    mv_val;
  logic                    mv_ovf;
  logic                    out_free;

  assign cmd.ready = (state == S_IDLE);
  assign out_free  = !res.valid || res.ready;

  always_comb begin
    case (comp)
      2'd0: begin
        sel_v = vx; sel_dir = dir_x; sel_pos = pos_x;
      end
      2'd1: begin
        sel_v = vy; sel_dir = dir_y; sel_pos = pos_y;
      end
      default: begin
        sel_v = vz; sel_dir = dir_z; sel_pos = pos_z;
      end
    endcase
  end

  always_comb begin
    case (state)
      S_GAIN: begin
        mul_a = (comp == 2'd0) ? vx : vz;
        mul_b = INV_GAIN;
      end
      S_MOVE: begin
        mul_a = VEC_W'(sel_dir);
        mul_b = MB_W'($signed({1'b0, move_step}));
      end
      default: begin
        mul_a = sel_v;
        mul_b = MB_W'(sel_v);
      end
    endcase
  end

  assign cor_sx = vx >>> cnt;
  assign cor_sz = vz >>> cnt;
  assign cor_a  = atan_step(cnt);

  assign sq_bit  = SUM_W'(1) << {cnt, 1'b0};
  assign sq_test = root + sq_bit;
  assign sq_ge   = acc >= sq_test;
  assign root_next = sq_ge ? ((root >> 1) + sq_bit) : (root >> 1);

  assign dv_t  = (NUM_W + 2)'(len) << cnt;
  assign dv_ge = {2'b00, rem} >= dv_t;

  assign dp_mag = sel_v[VEC_W-1] ? VEC_W'(-sel_v) : VEC_W'(sel_v);
  assign dp_num = (NUM_W'(dp_mag) << 14) + NUM_W'(len >> 1);

  assign q_clamp  = (quot > QUO_W'(UNIT)) ? QUO_W'(UNIT) : quot;
  assign q_signed = neg ? -$signed(q_clamp) : $signed(q_clamp);

  assign mv_sum   = prod + PROD_W'(8192);
  assign mv_delta = mv_sum[14 +: DLT_W];
  assign mv_r     = back ? ((PW + 1)'(sel_pos) - (PW + 1)'(mv_delta))
                         : ((PW + 1)'(sel_pos) + (PW + 1)'(mv_delta));
  assign mv_ovf   = mv_r[PW] != mv_r[PW-1];
  assign mv_val   = !mv_ovf ? mv_r[PW-1:0]
                  : (mv_r[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}});

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      move_step <= STEP_RESET;
      dir_x     <= UNIT;
      dir_y     <= '0;
      dir_z     <= '0;
      pos_x     <= PW'(-131072);
      pos_y     <= PW'(-131072);
      pos_z     <= '0;
      res.valid <= 1'b0;
      cnt       <= '0;
      comp      <= '0;
      ph        <= 1'b0;
      back      <= 1'b0;
      degen     <= 1'b0;
      clip      <= 1'b0;
    end else begin
      if (wr_en) begin
        move_step <= wr_data;
      end
      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            degen <= 1'b0;
            clip  <= 1'b0;
            comp  <= '0;
            ph    <= 1'b0;
            back  <= (cmd.action == ACT_BACK);
            vx    <= VEC_W'(dir_x) <<< 6;
            vz    <= VEC_W'(dir_z) <<< 6;
            vy    <= (VEC_W'(dir_y) <<< 6) + (VEC_W'(cmd.tilt_offset) <<< 8);
            ang   <= ANG_W'(cmd.turn_angle) <<< 12;
            if (cmd.action == ACT_ROTATE) begin
              state <= S_WRAP;
            end else if (cmd.action == ACT_FORWARD || cmd.action == ACT_BACK) begin
              state <= S_MOVE;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_WRAP: begin
          if (ang > ANG_PI) begin
            ang <= ang - ANG_TWO_PI;
          end else if (ang < -ANG_PI) begin
            ang <= ang + ANG_TWO_PI;
          end
          state <= S_FOLD;
        end
        S_FOLD: begin
          if (ang > ANG_HALF_PI) begin
            ang <= ang - ANG_PI;
            vx  <= -vx;
            vz  <= -vz;
          end else if (ang < -ANG_HALF_PI) begin
            ang <= ang + ANG_PI;
            vx  <= -vx;
            vz  <= -vz;
          end
          cnt   <= '0;
          state <= S_CORDIC;
        end
        S_CORDIC: begin
          if (!ang[ANG_W-1]) begin
            vx  <= vx - cor_sz;
            vz  <= vz + cor_sx;
            ang <= ang - cor_a;
          end else begin
            vx  <= vx + cor_sz;
            vz  <= vz - cor_sx;
            ang <= ang + cor_a;
          end
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(ROTATE_ITERATIONS - 1)) begin
            comp  <= '0;
            ph    <= 1'b0;
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          ph <= !ph;
          if (ph) begin
            if (comp == 2'd0) begin
              vx   <= prod[30 +: VEC_W];
              comp <= 2'd1;
            end else begin
              vz    <= prod[30 +: VEC_W];
              comp  <= '0;
              acc   <= '0;
              state <= S_SQ;
            end
          end
        end
        S_SQ: begin
          ph <= !ph;
          if (ph) begin
            acc <= acc + prod[SUM_W-1:0];
            if (comp == 2'd2) begin
              comp  <= '0;
              cnt   <= CNT_W'(SQRT_STEPS - 1);
              root  <= '0;
              state <= S_SQRT;
            end else begin
              comp <= comp + 2'd1;
            end
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            acc <= acc - sq_test;
          end
          root <= root_next;
          cnt  <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            len <= root_next[LEN_W-1:0];
            if (root_next == '0) begin
              degen <= 1'b1;
              state <= S_DONE;
            end else begin
              state <= S_DPREP;
            end
          end
        end
        S_DPREP: begin
          neg   <= sel_v[VEC_W-1];
          rem   <= dp_num;
          quot  <= '0;
          cnt   <= CNT_W'(DIV_STEPS - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          if (dv_ge) begin
            rem <= rem - dv_t[NUM_W-1:0];
          end
          quot <= {quot[QUO_W-2:0], dv_ge};
          cnt  <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= S_DSTORE;
          end
        end
        S_DSTORE: begin
          case (comp)
            2'd0:    dir_x <= q_signed;
            2'd1:    dir_y <= q_signed;
            default: dir_z <= q_signed;
          endcase
          if (comp == 2'd2) begin
            state <= S_DONE;
          end else begin
            comp  <= comp + 2'd1;
            state <= S_DPREP;
          end
        end
        S_MOVE: begin
          ph <= !ph;
          if (ph) begin
            case (comp)
              2'd0:    pos_x <= mv_val;
              2'd1:    pos_y <= mv_val;
              default: pos_z <= mv_val;
            endcase
            if (mv_ovf) begin
              clip <= 1'b1;
            end
            if (comp == 2'd2) begin
              state <= S_DONE;
            end else begin
              comp <= comp + 2'd1;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            res.valid      <= 1'b1;
            res.view_x     <= dir_x;
            res.view_y     <= dir_y;
            res.view_z     <= dir_z;
            res.where_x    <= pos_x;
            res.where_y    <= pos_y;
            res.where_z    <= pos_z;
            res.degenerate <= degen;
            res.clipped    <= clip;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CRM_ASSERT_NEXT(a_busy_after_accept, clk, rst, cmd.valid && cmd.ready, !cmd.ready)
  `CRM_ASSERT_NOW(a_view_x_unit, clk, rst, res.valid, res.view_x <= UNIT && res.view_x >= -UNIT)
  `CRM_ASSERT_NOW(a_view_y_unit, clk, rst, res.valid, res.view_y <= UNIT && res.view_y >= -UNIT)
  `CRM_ASSERT_NOW(a_one_flag, clk, rst, res.valid, !(res.degenerate && res.clipped))

endmodule
